### sv/lpcf_pkg.sv
// Package with shared widths, register indexes and the sideband type of the crop filter.
`timescale 1ns / 1ps

package lpcf_pkg;

  localparam int unsigned CoordW     = 24;  // point and vehicle coordinates
  localparam int unsigned TimeW      = 32;  // scan time stamps and age
  localparam int unsigned RzW        = 25;  // relative height, one bit of growth
  localparam int unsigned AbsW       = 24;  // magnitude of a coordinate difference
  localparam int unsigned SqW        = 48;  // square of one magnitude
  localparam int unsigned SumW       = 49;  // sum of two squares
  localparam int unsigned RadW       = 50;  // working width of the square root
  localparam int unsigned DisW       = 25;  // horizontal distance
  localparam int unsigned SlopeW     = 8;
  localparam int unsigned HeightW    = 17;
  localparam int unsigned WidenW     = 33;  // slope times distance
  localparam int unsigned BandW      = 35;  // Q8 band limits and relative height
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 24;
  localparam int unsigned SqrtStages = 25;  // one result bit per stage

  localparam logic [DisW-1:0] MinDisMm = DisW'(500);

  typedef enum logic [CfgIdxW-1:0] {
    CfgVehX      = 3'd0,
    CfgVehY      = 3'd1,
    CfgVehZ      = 3'd2,
    CfgMinHeight = 3'd3,
    CfgMaxHeight = 3'd4,
    CfgSlope     = 3'd5,
    CfgMaxRadius = 3'd6
  } cfg_idx_e;

  // Everything an item carries alongside the distance computation.
  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
    logic        [TimeW-1:0]  age;
    logic                     last;
    logic signed [RzW-1:0]    rz;
  } side_t;

endpackage

### sv/lpcf_isqrt.sv
// Pipelined integer square root, one result bit per stage, with a sideband carried along.
`timescale 1ns / 1ps

module lpcf_isqrt import lpcf_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [SumW-1:0] rad_i,
  input  side_t           side_i,
  output logic            valid_o,
  output logic [DisW-1:0] root_o,
  output side_t           side_o
);

  logic [SqrtStages-1:0] vld_q;
  logic [RadW-1:0]       rem_q    [SqrtStages];
  logic [RadW-1:0]       root_q   [SqrtStages];
  side_t                 side_q   [SqrtStages];

  logic [SqrtStages-1:0] vld_prev;
  logic [RadW-1:0]       rem_prev  [SqrtStages];
  logic [RadW-1:0]       root_prev [SqrtStages];
  side_t                 side_prev [SqrtStages];
  logic [RadW-1:0]       trial     [SqrtStages];
  logic [SqrtStages-1:0] fits;

  for (genvar g = 0; g < SqrtStages; g++) begin : g_stage
    localparam logic [RadW-1:0] StepBit = RadW'(1) << (2 * (SqrtStages - 1 - g));

    if (g == 0) begin : g_first
      assign vld_prev[g]  = valid_i;
      assign rem_prev[g]  = RadW'(rad_i);
      assign root_prev[g] = '0;
      assign side_prev[g] = side_i;
    end else begin : g_next
      assign vld_prev[g]  = vld_q[g-1];
      assign rem_prev[g]  = rem_q[g-1];
      assign root_prev[g] = root_q[g-1];
      assign side_prev[g] = side_q[g-1];
    end

    assign trial[g] = root_prev[g] + StepBit;
    assign fits[g]  = rem_prev[g] >= trial[g];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (en_i) begin
        vld_q[g] <= vld_prev[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[g] <= side_prev[g];
        if (fits[g]) begin
          rem_q[g]  <= rem_prev[g] - trial[g];
          root_q[g] <= (root_prev[g] >> 1) + StepBit;
        end else begin
          rem_q[g]  <= rem_prev[g];
          root_q[g] <= root_prev[g] >> 1;
        end
      end
    end
  end

  assign valid_o = vld_q[SqrtStages-1];
  assign root_o  = root_q[SqrtStages-1][DisW-1:0];
  assign side_o  = side_q[SqrtStages-1];

endmodule

### sv/lidar_point_crop_filter.sv
// Top level of the lidar point crop filter: region-of-interest test on a stream of points.
`timescale 1ns / 1ps

//  channel   signals                               direction  beat when
//  --------  ------------------------------------  ---------  -------------------------
//  in        in_valid_i/in_ready_o, point fields   into block valid and ready high
//  out       out_valid_o/out_ready_i, result       out        valid and ready high
//  config    cfg_we_i, cfg_idx_i, cfg_data_i       into block write enable high
//
// One point enters every cycle while the output is not stalled. The pipeline is made of
// the 25-stage square root pipeline, plus one stage for the differences, one for the
// squares, one for their sum, one for the slope product and one output register. Reset
// clears all valid bits and the start-time latch and sets the configuration registers to
// their defaults. A stall at the output freezes the whole pipeline; a skid register at the
// input catches the one beat that may arrive while the pipeline is frozen, so no beat is
// lost or repeated and in_ready_o does not depend on out_ready_i combinationally.

module lidar_point_crop_filter import lpcf_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Configuration write port.
  input  logic                     cfg_we_i,
  input  logic [CfgIdxW-1:0]       cfg_idx_i,
  input  logic [CfgDataW-1:0]      cfg_data_i,
  // Input points.
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [CoordW-1:0] point_x_i,
  input  logic signed [CoordW-1:0] point_y_i,
  input  logic signed [CoordW-1:0] point_z_i,
  input  logic [TimeW-1:0]         scan_time_ms_i,
  input  logic                     last_in_scan_i,
  // Results.
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     keep_o,
  output logic signed [CoordW-1:0] out_x_o,
  output logic signed [CoordW-1:0] out_y_o,
  output logic signed [CoordW-1:0] out_z_o,
  output logic [TimeW-1:0]         age_ms_o,
  output logic                     last_out_o
);

  // Configuration registers.
  logic signed [CoordW-1:0]  veh_x_q, veh_y_q, veh_z_q;
  logic signed [HeightW-1:0] min_h_q, max_h_q;
  logic [SlopeW-1:0]         slope_q;
  logic [CoordW-1:0]         max_radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      veh_x_q      <= '0;
      veh_y_q      <= '0;
      veh_z_q      <= '0;
      min_h_q      <= -HeightW'(1500);
      max_h_q      <= HeightW'(200);
      slope_q      <= SlopeW'(51);
      max_radius_q <= CoordW'(11000);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgVehX:      veh_x_q      <= cfg_data_i;
        CfgVehY:      veh_y_q      <= cfg_data_i;
        CfgVehZ:      veh_z_q      <= cfg_data_i;
        CfgMinHeight: min_h_q      <= cfg_data_i[HeightW-1:0];
        CfgMaxHeight: max_h_q      <= cfg_data_i[HeightW-1:0];
        CfgSlope:     slope_q      <= cfg_data_i[SlopeW-1:0];
        CfgMaxRadius: max_radius_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The whole pipeline advances together whenever the output register can take a beat.
  logic en;
  logic out_valid_q;
  assign en = !out_valid_q || out_ready_i;

  // Input skid register: holds a beat that arrived while the pipeline was frozen.
  logic                     skid_valid_q;
  logic signed [CoordW-1:0] skid_x_q, skid_y_q, skid_z_q;
  logic [TimeW-1:0]         skid_t_q;
  logic                     skid_last_q;
  logic                     in_fire;

  assign in_ready_o = !skid_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_valid_q <= 1'b0;
    end else if (en) begin
      skid_valid_q <= 1'b0;
    end else if (in_fire) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && !en) begin
      skid_x_q    <= point_x_i;
      skid_y_q    <= point_y_i;
      skid_z_q    <= point_z_i;
      skid_t_q    <= scan_time_ms_i;
      skid_last_q <= last_in_scan_i;
    end
  end

  // Source of the beat entering the pipeline: the skid register drains first.
  logic                     src_valid;
  logic signed [CoordW-1:0] src_x, src_y, src_z;
  logic [TimeW-1:0]         src_t;
  logic                     src_last;

  assign src_valid = skid_valid_q || in_fire;
  assign src_x     = skid_valid_q ? skid_x_q    : point_x_i;
  assign src_y     = skid_valid_q ? skid_y_q    : point_y_i;
  assign src_z     = skid_valid_q ? skid_z_q    : point_z_i;
  assign src_t     = skid_valid_q ? skid_t_q    : scan_time_ms_i;
  assign src_last  = skid_valid_q ? skid_last_q : last_in_scan_i;

  // The first point after reset latches the start time, so its own age is zero.
  logic             started_q;
  logic [TimeW-1:0] start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      start_q   <= '0;
    end else if (en && src_valid && !started_q) begin
      started_q <= 1'b1;
      start_q   <= src_t;
    end
  end

  // Stage 1: coordinate differences and their magnitudes, relative height, age.
  logic signed [RzW-1:0] dx, dy, rz;
  logic [AbsW-1:0]       ax, ay;
  logic [TimeW-1:0]      age;

  assign dx  = RzW'(src_x) - RzW'(veh_x_q);
  assign dy  = RzW'(src_y) - RzW'(veh_y_q);
  assign rz  = RzW'(src_z) - RzW'(veh_z_q);
  assign ax  = dx[RzW-1] ? AbsW'(-dx) : AbsW'(dx);
  assign ay  = dy[RzW-1] ? AbsW'(-dy) : AbsW'(dy);
  assign age = started_q ? (src_t - start_q) : '0;

  logic            v1_q;
  logic [AbsW-1:0] ax_q, ay_q;
  side_t           side1_q;

  // Stage 2: squares.  Stage 3: sum of squares.
  logic            v2_q;
  logic [SqW-1:0]  sqx_q, sqy_q;
  side_t           side2_q;
  logic            v3_q;
  logic [SumW-1:0] sum_q;
  side_t           side3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= src_valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax_q         <= ax;
      ay_q         <= ay;
      side1_q.x    <= src_x;
      side1_q.y    <= src_y;
      side1_q.z    <= src_z;
      side1_q.age  <= age;
      side1_q.last <= src_last;
      side1_q.rz   <= rz;
      sqx_q        <= SqW'(ax_q) * SqW'(ax_q);
      sqy_q        <= SqW'(ay_q) * SqW'(ay_q);
      side2_q      <= side1_q;
      sum_q        <= SumW'(sqx_q) + SumW'(sqy_q);
      side3_q      <= side2_q;
    end
  end

  // Stages 4 to 28: floor of the square root, one bit per stage.
  logic            vr;
  logic [DisW-1:0] dis;
  side_t           sider;

  lpcf_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .rad_i   (sum_q),
    .side_i  (side3_q),
    .valid_o (vr),
    .root_o  (dis),
    .side_o  (sider)
  );

  // Stage 29: band widening and the radius window.
  logic              v4_q;
  logic [WidenW-1:0] widen_q;
  logic              dis_ok_q;
  side_t             side4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= vr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      widen_q  <= WidenW'(slope_q) * WidenW'(dis);
      dis_ok_q <= (dis < DisW'(max_radius_q)) && (dis > MinDisMm);
      side4_q  <= sider;
    end
  end

  // Stage 30: height band test at Q8 scale, then the output register.
  logic signed [BandW-1:0] rz_q8, lo_q8, hi_q8, widen_s;
  logic                    keep;

  assign rz_q8   = {{(BandW-RzW-8){side4_q.rz[RzW-1]}}, side4_q.rz, 8'b0};
  assign widen_s = $signed(BandW'(widen_q));
  assign lo_q8   = {{(BandW-HeightW-8){min_h_q[HeightW-1]}}, min_h_q, 8'b0} - widen_s;
  assign hi_q8   = {{(BandW-HeightW-8){max_h_q[HeightW-1]}}, max_h_q, 8'b0} + widen_s;
  assign keep    = (rz_q8 > lo_q8) && (rz_q8 < hi_q8) && dis_ok_q;

  logic                     keep_q;
  logic signed [CoordW-1:0] out_x_q, out_y_q, out_z_q;
  logic [TimeW-1:0]         age_q;
  logic                     last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      keep_q  <= keep;
      out_x_q <= side4_q.x;
      out_y_q <= side4_q.y;
      out_z_q <= side4_q.z;
      age_q   <= side4_q.age;
      last_q  <= side4_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign keep_o      = keep_q;
  assign out_x_o     = out_x_q;
  assign out_y_o     = out_y_q;
  assign out_z_o     = out_z_q;
  assign age_ms_o    = age_q;
  assign last_out_o  = last_q;

endmodule

### sv/lpcf_checker.sv
// Port-level checker for the crop filter and its bind to the top level.
`timescale 1ns / 1ps

module lpcf_checker import lpcf_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic                     keep_o,
  input logic signed [CoordW-1:0] out_x_o,
  input logic signed [CoordW-1:0] out_y_o,
  input logic signed [CoordW-1:0] out_z_o,
  input logic [TimeW-1:0]         age_ms_o,
  input logic                     last_out_o
);

  // Set until the first result beat has been taken.
  logic first_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
    end else if (out_valid_o && out_ready_i) begin
      first_q <= 1'b0;
    end
  end

  // A stalled result holds its beat unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(keep_o) && $stable(out_x_o)
      && $stable(out_y_o) && $stable(out_z_o) && $stable(age_ms_o) && $stable(last_out_o))
    else $error("result beat changed while stalled");

  // The first result after reset measures age from its own scan time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && first_q |-> age_ms_o == '0)
    else $error("first result has nonzero age");

  // Input backpressure only comes from a beat taken while the output was stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(in_valid_i && out_valid_o && !out_ready_i))
    else $error("input ready dropped without an output stall");

  // Once the output moves, the held input beat drains and ready returns.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o && (out_ready_i || !out_valid_o) |=> in_ready_o)
    else $error("input ready did not return after the stall cleared");

endmodule

bind lidar_point_crop_filter lpcf_checker u_lpcf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .keep_o      (keep_o),
  .out_x_o     (out_x_o),
  .out_y_o     (out_y_o),
  .out_z_o     (out_z_o),
  .age_ms_o    (age_ms_o),
  .last_out_o  (last_out_o)
);
